/* hdl/nal_header_and_emulation_strip_top_assert.svh */
// Assertion macros for the NAL header and emulation strip block.
// No dependencies; included by the modules that carry assertions.
`ifndef NAL_HEADER_AND_EMULATION_STRIP_TOP_ASSERT_SVH
`define NAL_HEADER_AND_EMULATION_STRIP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NHES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NHES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NHES_ASSERT(lbl, clk, rst_n, prop, msg)
`define NHES_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/nhes_pkg.sv */
// Shared types and constants for the NAL header and emulation strip block.
// No dependencies.
package nhes_pkg;

  localparam int unsigned CFG_AW = 3;

  localparam logic [7:0] EPB_BYTE     = 8'h03;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;
  localparam logic [1:0] ZRUN_SAT     = 2'd2;
  localparam logic       HDR_FMT_HEVC = 1'b0;
  localparam logic       HDR_FMT_VVC  = 1'b1;
  localparam logic       HDR_FMT_RST  = HDR_FMT_VVC;

  localparam logic       REG_HEADER_FORMAT = 1'b0;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    POS_HDR0    = 2'd0,
    POS_HDR1    = 2'd1,
    POS_PAYLOAD = 2'd2
  } pos_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        end_mark;
    logic        forbidden_bit;
    logic        reserved_bit;
    logic [5:0]  layer_id;
    logic [5:0]  unit_type;
    logic [2:0]  temporal_plus1;
    logic [2:0]  temporal_id;
    logic        is_slice;
  } result_t;

endpackage

/* hdl/nhes_parse.sv */
// Header unpacking and emulation-prevention removal for one request per cycle.
// Depends on nhes_pkg and the assertion macro header.
`include "nal_header_and_emulation_strip_top_assert.svh"

module nhes_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                header_format,
  input  logic                acc,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                res_vld,
  output nhes_pkg::result_t   res
);

  nhes_pkg::pos_t pos_r, pos_nxt;
  logic [1:0]     zrun_r, zrun_nxt;
  logic [7:0]     hdr0_r, hdr0_nxt;

  logic           epb;
  logic [4:0]     vvc_type;
  logic [2:0]     tp1;

  assign epb      = (zrun_r == nhes_pkg::ZRUN_SAT) && (in_byte == nhes_pkg::EPB_BYTE);
  assign vvc_type = in_byte[7:3];
  assign tp1      = in_byte[2:0];

  always_comb begin
    pos_nxt  = pos_r;
    zrun_nxt = zrun_r;
    hdr0_nxt = hdr0_r;
    if (acc) begin
      unique case (pos_r)
        nhes_pkg::POS_HDR0: begin
          hdr0_nxt = in_byte;
          pos_nxt  = in_last ? nhes_pkg::POS_HDR0 : nhes_pkg::POS_HDR1;
          zrun_nxt = 2'd0;
        end
        nhes_pkg::POS_HDR1: begin
          pos_nxt  = in_last ? nhes_pkg::POS_HDR0 : nhes_pkg::POS_PAYLOAD;
          zrun_nxt = 2'd0;
        end
        default: begin
          if (epb || in_byte != nhes_pkg::ZERO_BYTE) begin
            zrun_nxt = 2'd0;
          end else if (zrun_r != nhes_pkg::ZRUN_SAT) begin
            zrun_nxt = zrun_r + 2'd1;
          end
          if (in_last) begin
            pos_nxt  = nhes_pkg::POS_HDR0;
            zrun_nxt = 2'd0;
          end
        end
      endcase
    end
  end

  always_comb begin
    res     = '0;
    res_vld = 1'b0;
    unique case (pos_r)
      nhes_pkg::POS_HDR0: begin
        if (in_last) begin
          res_vld      = 1'b1;
          res.kind     = nhes_pkg::KIND_ERROR;
          res.end_mark = 1'b1;
        end
      end
      nhes_pkg::POS_HDR1: begin
        res_vld = 1'b1;
        if (in_last) begin
          res.kind     = nhes_pkg::KIND_ERROR;
          res.end_mark = 1'b1;
        end else begin
          res.kind           = nhes_pkg::KIND_HEADER;
          res.forbidden_bit  = hdr0_r[7];
          res.temporal_plus1 = tp1;
          res.temporal_id    = (tp1 == 3'd0) ? 3'd0 : tp1 - 3'd1;
          if (header_format == nhes_pkg::HDR_FMT_VVC) begin
            res.reserved_bit = hdr0_r[6];
            res.layer_id     = hdr0_r[5:0];
            res.unit_type    = {1'b0, vvc_type};
            res.is_slice     = (vvc_type <= 5'd3) ||
                               ((vvc_type >= 5'd7) && (vvc_type <= 5'd10));
          end else begin
            res.unit_type = hdr0_r[6:1];
            res.layer_id  = {hdr0_r[0], in_byte[7:3]};
          end
        end
      end
      default: begin
        if (epb) begin
          if (in_last) begin
            res_vld      = 1'b1;
            res.kind     = nhes_pkg::KIND_END;
            res.end_mark = 1'b1;
          end
        end else begin
          res_vld       = 1'b1;
          res.kind      = nhes_pkg::KIND_PAYLOAD;
          res.data_byte = in_byte;
          res.end_mark  = in_last;
        end
      end
    endcase
    res_vld = res_vld & acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= nhes_pkg::POS_HDR0;
      zrun_r <= 2'd0;
      hdr0_r <= 8'd0;
    end else begin
      pos_r  <= pos_nxt;
      zrun_r <= zrun_nxt;
      hdr0_r <= hdr0_nxt;
    end
  end

  `NHES_ASSERT(a_last_ends_unit, clk, rst_n, acc && in_last |=> pos_r == nhes_pkg::POS_HDR0 && zrun_r == 2'd0, "unit end did not restart parsing")
  `NHES_ASSERT(a_zrun_sat, clk, rst_n, zrun_r != 2'd3, "zero run passed saturation")
  `NHES_ASSERT(a_header_pos, clk, rst_n, res_vld && res.kind == nhes_pkg::KIND_HEADER |-> pos_r == nhes_pkg::POS_HDR1, "header result outside second header byte")

endmodule

/* hdl/nhes_outbuf.sv */
// Result register with a skid stage that holds one request pushed under stall.
// Depends on nhes_pkg and the assertion macro header.
`include "nal_header_and_emulation_strip_top_assert.svh"

module nhes_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nhes_pkg::result_t   res,
  output logic                in_rdy,
  output logic                out_vld,
  input  logic                out_rdy,
  output nhes_pkg::result_t   out_res
);

  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  nhes_pkg::result_t out_r, out_nxt;
  nhes_pkg::result_t skid_r, skid_nxt;
  logic              out_free;

  assign out_free = !out_vld_r || out_rdy;
  assign in_rdy   = !skid_vld_r;
  assign out_vld  = out_vld_r;
  assign out_res  = out_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (out_free) begin
      out_vld_nxt  = skid_vld_r || push;
      out_nxt      = skid_vld_r ? skid_r : res;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  `NHES_ASSERT(a_skid_behind_out, clk, rst_n, skid_vld_r |-> out_vld_r, "skid holds a request ahead of the output")
  `NHES_ASSERT(a_stall_to_skid, clk, rst_n, out_vld_r && !out_rdy && push |=> skid_vld_r, "stalled request not held in skid")
  `NHES_ASSERT(a_skid_holds, clk, rst_n, skid_vld_r && !out_rdy |=> skid_vld_r && $stable(skid_r), "skid request lost under stall")

endmodule

/* hdl/nal_header_and_emulation_strip_top.sv */
// Channel     Dir  Handshake         Payload
// in_         in   tvalid/tready     tdata: byte; tlast: last byte of unit
// out_        out  tvalid/tready     tuser: kind; tdata: result fields; tlast: end
// cfg_        in   APB psel/penable  register 0: header_format
//
// One request is taken per cycle while in_tready is high; results are registered.
// The rate is set by the result register and its skid stage: in_tready drops
// only while the skid stage holds a result. rst_n is synchronous, active low,
// and clears parse state, valid flags and header_format (to the VVC layout).
// Depends on nhes_pkg, nhes_parse and nhes_outbuf.
module nal_header_and_emulation_strip_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] data_byte, [8] forbidden_bit, [9] reserved_bit, [15:10] layer_id,
  // [21:16] unit_type, [24:22] temporal_plus1, [27:25] temporal_id, [28] is_slice
  output logic [31:0]                 out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nhes_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic              hdr_fmt_r, hdr_fmt_nxt;
  logic              reg_idx;
  logic              cfg_wr;
  logic              acc;
  logic              res_vld;
  nhes_pkg::result_t res;
  nhes_pkg::result_t out_res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[nhes_pkg::CFG_AW-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    hdr_fmt_nxt = hdr_fmt_r;
    cfg_prdata  = 32'd0;
    unique case (reg_idx)
      nhes_pkg::REG_HEADER_FORMAT: begin
        cfg_prdata = {31'd0, hdr_fmt_r};
        if (cfg_wr) begin
          hdr_fmt_nxt = cfg_pwdata[0];
        end
      end
      default: begin
        cfg_prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_fmt_r <= nhes_pkg::HDR_FMT_RST;
    end else begin
      hdr_fmt_r <= hdr_fmt_nxt;
    end
  end

  assign acc = in_tvalid && in_tready;

  nhes_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .header_format (hdr_fmt_r),
    .acc           (acc),
    .in_byte       (in_tdata),
    .in_last       (in_tlast),
    .res_vld       (res_vld),
    .res           (res)
  );

  nhes_outbuf u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_vld),
    .res     (res),
    .in_rdy  (in_tready),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.end_mark;
  assign out_tdata = {3'd0,
                      out_res.is_slice,
                      out_res.temporal_id,
                      out_res.temporal_plus1,
                      out_res.unit_type,
                      out_res.layer_id,
                      out_res.reserved_bit,
                      out_res.forbidden_bit,
                      out_res.data_byte};

endmodule
